[hw/rtl/weighted_markov_chord_step_macros.svh]
// Assertion macros for the weighted Markov chord step block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef WEIGHTED_MARKOV_CHORD_STEP_MACROS_SVH
`define WEIGHTED_MARKOV_CHORD_STEP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define WMCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define WMCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/wmcs_pkg.sv]
// Package for the weighted Markov chord step block: widths, mode codes,
// the two transition weight tables and helper functions. No dependencies.
package wmcs_pkg;

    localparam int WORD_W  = 32;
    localparam int DEG_W   = 3;
    localparam int MODE_W  = 3;
    localparam int WGT_W   = 3;
    localparam int SUM_W   = 5;
    localparam int CNT_W   = $clog2(WORD_W);
    localparam int NUM_DEG = 7;

    localparam logic [DEG_W-1:0]  LAST_DEG     = DEG_W'(NUM_DEG - 1);
    localparam logic [DEG_W-1:0]  TONIC        = '0;
    localparam logic [MODE_W-1:0] MODE_MAJOR_A = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_MAJOR_B = MODE_W'(5);

    typedef logic [WGT_W-1:0] wgt_t;
    typedef logic [SUM_W-1:0] sum_t;

    localparam wgt_t MAJOR_TBL [0:NUM_DEG-1][0:NUM_DEG-1] = '{
        '{3'd2, 3'd1, 3'd1, 3'd4, 3'd4, 3'd3, 3'd1},
        '{3'd3, 3'd0, 3'd0, 3'd1, 3'd5, 3'd0, 3'd0},
        '{3'd2, 3'd0, 3'd0, 3'd2, 3'd1, 3'd4, 3'd0},
        '{3'd4, 3'd1, 3'd0, 3'd1, 3'd4, 3'd2, 3'd0},
        '{3'd5, 3'd0, 3'd0, 3'd1, 3'd0, 3'd3, 3'd0},
        '{3'd2, 3'd4, 3'd0, 3'd4, 3'd2, 3'd0, 3'd0},
        '{3'd4, 3'd0, 3'd0, 3'd0, 3'd2, 3'd0, 3'd0}
    };

    localparam wgt_t MINOR_TBL [0:NUM_DEG-1][0:NUM_DEG-1] = '{
        '{3'd3, 3'd1, 3'd2, 3'd3, 3'd3, 3'd2, 3'd3},
        '{3'd3, 3'd0, 3'd0, 3'd0, 3'd2, 3'd0, 3'd0},
        '{3'd3, 3'd0, 3'd0, 3'd2, 3'd1, 3'd2, 3'd1},
        '{3'd3, 3'd1, 3'd0, 3'd1, 3'd2, 3'd0, 3'd2},
        '{3'd4, 3'd0, 3'd0, 3'd1, 3'd0, 3'd1, 3'd1},
        '{3'd2, 3'd0, 3'd1, 3'd3, 3'd1, 3'd0, 3'd2},
        '{3'd4, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd0}
    };

    function automatic logic is_major(input logic [MODE_W-1:0] mode);
        return (mode == MODE_MAJOR_A) || (mode == MODE_MAJOR_B);
    endfunction

    // Out-of-range degree wraps to the tonic row (degree modulo seven)
    function automatic wgt_t weight(input logic major, input logic [DEG_W-1:0] row,
                                    input logic [DEG_W-1:0] col);
        logic [DEG_W-1:0] r;
        logic [DEG_W-1:0] c;
        r = (row > LAST_DEG) ? TONIC : row;
        c = (col > LAST_DEG) ? TONIC : col;
        return major ? MAJOR_TBL[r][c] : MINOR_TBL[r][c];
    endfunction

    function automatic sum_t row_sum(input logic major, input logic [DEG_W-1:0] row);
        sum_t acc;
        acc = '0;
        for (int i = 0; i < NUM_DEG; i++) begin
            acc = acc + SUM_W'(weight(major, row, DEG_W'(i)));
        end
        return acc;
    endfunction

endpackage

[hw/rtl/weighted_markov_chord_step.sv]
// Weighted Markov chord step: one transfer in, one chord degree out.
// Steps from input transfer to result valid: the bit-serial remainder unit, the
// weight scan, then a register for the result. A new item is taken only after the
// last result is loaded into the output register, which waits on any output stall.
// Reset (rst_n low, asynchronous) sets degree and scale mode to 0, drops valid.
// Depends on wmcs_pkg and weighted_markov_chord_step_macros.svh.
module weighted_markov_chord_step (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [wmcs_pkg::MODE_W-1:0]    scale_mode,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [wmcs_pkg::WORD_W-1:0]    random_word,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [wmcs_pkg::DEG_W-1:0]     chord_degree
);
    import wmcs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_PUSH = 2'd3;

    logic [1:0]        state_reg,  state_next;
    logic [MODE_W-1:0] mode_reg;
    logic [DEG_W-1:0]  cur_reg,    cur_next;
    logic [WORD_W-1:0] word_reg,   word_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    sum_t              total_reg,  total_next;
    sum_t              rem_reg,    rem_next;
    sum_t              run_reg,    run_next;
    logic [DEG_W-1:0]  idx_reg,    idx_next;
    logic [DEG_W-1:0]  res_reg,    res_next;
    logic              ovalid_reg, ovalid_next;
    logic [DEG_W-1:0]  odeg_reg,   odeg_next;

    logic              major;
    logic [SUM_W:0]    rem_shift;
    logic [SUM_W:0]    rem_diff;
    sum_t              run_sum;
    logic              push_go;

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = ovalid_reg;
    assign chord_degree = odeg_reg;

    // Combinational datapath: restoring remainder step, running weight sum and push condition
    assign major     = is_major(mode_reg);
    assign rem_shift = {rem_reg, word_reg[WORD_W-1]};
    assign rem_diff  = rem_shift - {1'b0, total_reg};
    assign run_sum   = run_reg + SUM_W'(weight(major, cur_reg, idx_reg));
    assign push_go   = !ovalid_reg || out_ready;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        word_next   = word_reg;
        cnt_next    = cnt_reg;
        total_next  = total_reg;
        rem_next    = rem_reg;
        run_next    = run_reg;
        idx_next    = idx_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg;
        odeg_next   = odeg_reg;

        // drop result once the consumer takes it
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    word_next  = random_word;
                    total_next = row_sum(major, cur_reg);
                    rem_next   = '0;
                    cnt_next   = CNT_W'(WORD_W - 1);
                    if (row_sum(major, cur_reg) == '0)
                    begin
                        res_next   = TONIC;
                        state_next = S_PUSH;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                // one quotient bit per cycle, keep only the remainder
                rem_next  = rem_diff[SUM_W] ? rem_shift[SUM_W-1:0] : rem_diff[SUM_W-1:0];
                word_next = {word_reg[WORD_W-2:0], 1'b0};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_next   = '0;
                    idx_next   = TONIC;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // advance through the row until the running total passes the draw
                run_next = run_sum;
                idx_next = idx_reg + 1'b1;
                if (rem_reg < run_sum)
                begin
                    res_next   = idx_reg;
                    state_next = S_PUSH;
                end
                else if (idx_reg == LAST_DEG)
                begin
                    res_next   = cur_reg;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                // hold until the output register is free
                if (push_go)
                begin
                    ovalid_next = 1'b1;
                    odeg_next   = res_reg;
                    cur_next    = res_reg;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cur_reg    <= TONIC;
            mode_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            ovalid_reg <= ovalid_next;
            if (cfg_we)
            begin
                mode_reg <= scale_mode;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        cnt_reg   <= cnt_next;
        total_reg <= total_next;
        rem_reg   <= rem_next;
        run_reg   <= run_next;
        idx_reg   <= idx_next;
        res_reg   <= res_next;
        odeg_reg  <= odeg_next;
    end

    `include "weighted_markov_chord_step_macros.svh"

    `WMCS_ASSERT_NOW(a_rem_below_total, state_reg == S_SCAN, rem_reg < total_reg, "remainder not below row sum")
    `WMCS_ASSERT_NEXT(a_busy_after_transfer, in_valid && in_ready, !in_ready, "ready after input transfer")
    `WMCS_ASSERT_NEXT(a_push_loads, state_reg == S_PUSH && push_go, out_valid && chord_degree == cur_reg, "result not loaded")
    `WMCS_ASSERT_NOW(a_degree_range, out_valid, chord_degree <= LAST_DEG, "degree out of range")

endmodule
